[design/tgq_pkg.sv]
// Package for the three-group quota assignment block.
// Holds payload, entry, command and status struct types, widths, codes and the saturating add.
// Used by every module of the design; depends on nothing.
package tgq_pkg;

    localparam int CostW  = 16;
    localparam int SumW   = 32;
    localparam int CapW   = 8;
    localparam int CntW   = 10;
    localparam int EpochW = 6;
    localparam int CfgIdxW = 2;

    localparam logic [CntW-1:0] StepLimit = 10'd1021;
    localparam logic [CntW-1:0] StampMax  = 10'd1023;

    typedef enum logic [CfgIdxW-1:0] {
        CfgCapX = 2'd0,
        CfgCapY = 2'd1,
        CfgCapZ = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CostW-1:0] cost_x;
        logic [CostW-1:0] cost_y;
        logic [CostW-1:0] cost_z;
        logic             last_item;
    } t_in_item;

    typedef struct packed {
        logic [SumW-1:0] min_cost;
        logic            feasible;
    } t_out_item;

    typedef struct packed {
        logic [EpochW-1:0] epoch;
        logic [CntW-1:0]   stamp;
        logic [SumW-1:0]   cost;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic init_wr;
        logic rd1;
        logic rd2;
        logic cell_wr;
        logic res_load;
    } t_cmd;

    typedef struct packed {
        logic seq_start;
        logic epoch_zero;
        logic clr_done;
        logic in_range;
        logic cell_last;
        logic last_item;
        logic out_full;
    } t_status;

    function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                                input logic [CostW-1:0] b);
        logic [SumW:0] s;
        s = {1'b0, a} + (SumW+1)'(b);
        return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
    endfunction

endpackage

[design/tgq_ctrl.sv]
// Controller state machine for the three-group quota assignment block.
// Sequences clearing, sequence start, the per-cell table scan and the result read.
// Depends on tgq_pkg for the command and status structs.
module tgq_ctrl
    import tgq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_START  = 9'b000000100,
        S_INIT   = 9'b000001000,
        S_RD1    = 9'b000010000,
        S_RD2    = 9'b000100000,
        S_WR     = 9'b001000000,
        S_RES_RD = 9'b010000000,
        S_RES    = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_act, n_act;

    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_done) begin
                    n_state = r_act ? S_INIT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_act        = 1'b1;
                    n_state      = S_START;
                end
            end
            S_START: begin
                priority if (i_status.seq_start) begin
                    n_state = i_status.epoch_zero ? S_CLEAR : S_INIT;
                end else if (i_status.in_range) begin
                    n_state = S_RD1;
                end else if (i_status.last_item) begin
                    n_state = S_RES_RD;
                end else begin
                    n_state = S_IDLE;
                    n_act   = 1'b0;
                end
            end
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                n_state       = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd2 = 1'b1;
                n_state   = S_WR;
            end
            S_WR: begin
                o_cmd.cell_wr = 1'b1;
                priority if (!i_status.cell_last) begin
                    n_state = S_RD1;
                end else if (i_status.last_item) begin
                    n_state = S_RES_RD;
                end else begin
                    n_state = S_IDLE;
                    n_act   = 1'b0;
                end
            end
            S_RES_RD: begin
                n_state = S_RES;
            end
            S_RES: begin
                if (!i_status.out_full) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                    n_act          = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_act   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_act   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[design/tgq_datapath.sv]
// Datapath for the three-group quota assignment block.
// Holds the caps, item registers, the cost table memory with step and epoch tags,
// the scan counters and the result register. Depends on tgq_pkg.
module tgq_datapath
    import tgq_pkg::*;
#(
    parameter int MAX_CAP = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_cfg_wr,
    input  logic [CfgIdxW-1:0]   i_cfg_index,
    input  logic [CapW-1:0]      i_cfg_data,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data
);

    localparam int CW    = (MAX_CAP < 1) ? 1 : $clog2(MAX_CAP + 1);
    localparam int AW    = 2 * CW;
    localparam int Depth = 2 ** AW;
    localparam int EW    = CntW + 2;
    localparam logic [CntW-1:0] MaxCapV = CntW'(MAX_CAP);

    t_entry r_mem [Depth];

    logic [CapW-1:0]   r_cap_x, r_cap_y, r_cap_z;
    t_in_item          r_item;
    logic [CW-1:0]     r_ax, r_ay, r_tx, r_ty;
    logic [CapW-1:0]   r_az;
    logic [CntW-1:0]   r_i, r_count;
    logic [EpochW-1:0] r_epoch;
    logic [AW-1:0]     r_clr;
    t_entry            r_rd_a, r_rd_b;
    logic [SumW-1:0]   r_self_sum, r_xm_sum;
    logic              r_self_ok, r_xm_ok;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [CntW-1:0]   capx_cl, capy_cl, cur, nxt;
    logic [AW-1:0]     rd_addr_a, rd_addr_b, wr_addr;
    logic              wr_en;
    t_entry            wr_data;
    logic signed [EW-1:0] e_val;
    logic              e_pos, e_le;
    logic              a_match, b_match;
    logic [SumW-1:0]   ym_sum, m1, best;
    logic              ym_ok, ok1;

    assign capx_cl = (CntW'(r_cap_x) > MaxCapV) ? MaxCapV : CntW'(r_cap_x);
    assign capy_cl = (CntW'(r_cap_y) > MaxCapV) ? MaxCapV : CntW'(r_cap_y);
    assign cur     = r_i + CntW'(1);
    assign nxt     = r_i + CntW'(2);

    assign e_val = $signed(EW'(r_i) + EW'(1) - EW'(r_tx) - EW'(r_ty));
    assign e_pos = !e_val[EW-1];
    assign e_le  = e_pos && (e_val[EW-2:0] <= (EW-1)'(r_az));

    assign a_match = (r_rd_a.epoch == r_epoch) && (r_rd_a.stamp == cur);
    assign b_match = (r_rd_b.epoch == r_epoch) && (r_rd_b.stamp == cur);

    always_comb begin
        priority if (i_cmd.rd1) begin
            rd_addr_a = {r_tx, r_ty};
        end else if (i_cmd.rd2) begin
            rd_addr_a = {r_tx, r_ty - CW'(1)};
        end else begin
            rd_addr_a = {r_ax, r_ay};
        end
        rd_addr_b = {r_tx - CW'(1), r_ty};
    end

    always_comb begin
        ym_sum = sat_add(r_rd_a.cost, r_item.cost_y);
        ym_ok  = (r_ty != '0) && a_match && e_le;
        m1     = (r_self_ok && (!r_xm_ok || r_self_sum <= r_xm_sum)) ? r_self_sum : r_xm_sum;
        ok1    = r_self_ok || r_xm_ok;
        best   = (ok1 && (!ym_ok || m1 <= ym_sum)) ? m1 : ym_sum;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {r_tx, r_ty};
        wr_data = '{epoch: r_epoch, stamp: nxt, cost: best};
        priority if (i_cmd.clr_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            wr_data = '0;
        end else if (i_cmd.init_wr) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '{epoch: r_epoch, stamp: CntW'(1), cost: '0};
        end else if (i_cmd.cell_wr) begin
            wr_en = ok1 || ym_ok;
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_data;
            r_ax   <= capx_cl[CW-1:0];
            r_ay   <= capy_cl[CW-1:0];
            r_az   <= r_cap_z;
            r_i    <= r_count;
            r_tx   <= capx_cl[CW-1:0];
            r_ty   <= capy_cl[CW-1:0];
        end else if (i_cmd.cell_wr) begin
            if (r_ty == '0) begin
                r_ty <= r_ay;
                r_tx <= r_tx - CW'(1);
            end else begin
                r_ty <= r_ty - CW'(1);
            end
        end
        if (i_cmd.rd2) begin
            r_self_sum <= sat_add(r_rd_a.cost, r_item.cost_z);
            r_self_ok  <= a_match && e_le && (e_val != '0);
            r_xm_sum   <= sat_add(r_rd_b.cost, r_item.cost_x);
            r_xm_ok    <= (r_tx != '0) && b_match && e_le;
        end
        if (i_cmd.res_load) begin
            r_out.feasible <= (r_i <= StepLimit) && (r_rd_a.epoch == r_epoch)
                              && (r_rd_a.stamp == nxt);
            r_out.min_cost <= ((r_i <= StepLimit) && (r_rd_a.epoch == r_epoch)
                              && (r_rd_a.stamp == nxt)) ? r_rd_a.cost : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_x     <= '0;
            r_cap_y     <= '0;
            r_cap_z     <= '0;
            r_count     <= '0;
            r_epoch     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                unique case (i_cfg_index)
                    CfgCapX: r_cap_x <= i_cfg_data;
                    CfgCapY: r_cap_y <= i_cfg_data;
                    CfgCapZ: r_cap_z <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                if (i_in_data.last_item) begin
                    r_count <= '0;
                end else if (r_count < StampMax) begin
                    r_count <= r_count + CntW'(1);
                end
                if (r_count == '0) begin
                    r_epoch <= r_epoch + EpochW'(1);
                end
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.seq_start  = (r_i == '0);
    assign o_status.epoch_zero = (r_epoch == '0);
    assign o_status.clr_done   = (r_clr == {AW{1'b1}});
    assign o_status.in_range   = (r_i <= StepLimit);
    assign o_status.cell_last  = (r_tx == '0) && (r_ty == '0);
    assign o_status.last_item  = r_item.last_item;
    assign o_status.out_full   = r_out_valid && i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[design/three_group_quota_assignment_dp_top.sv]
// Top level of the three-group quota assignment block.
// Joins the controller tgq_ctrl and the datapath tgq_datapath; uses tgq_pkg.
//
//   Channel   Direction  Handshake                       Payload
//   in        input      i_in_valid / o_in_stall         i_in_data  (t_in_item)
//   out       output     o_out_valid / i_out_stall       o_out_data (t_out_item)
//   cfg       input      i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// For an item, the table scan walks all (ax + 1) * (ay + 1) cells, with ax and ay the clamped caps:
// each cell is read in S_RD1 and S_RD2 and, when reachable, rewritten in S_WR in the cost table memory.
// The first item of a sequence adds the table start in S_INIT, and a last item adds the result read;
// an item past the 1022nd skips the scan and, when it is last, goes straight to the result read.
// After reset, and on every 64th sequence start, a clearing pass over all 2**(2*clog2(MAX_CAP+1))
// table entries (65536 at the default) runs while o_in_stall stays high.
// A result waits in the output register under i_out_stall; the next item is still taken,
// but a further result holds the block until the waiting transfer completes.
module three_group_quota_assignment_dp_top
    import tgq_pkg::*;
#(
    parameter int MAX_CAP = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CapW-1:0]    i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    tgq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    tgq_datapath #(
        .MAX_CAP (MAX_CAP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[design/tgq_checker.sv]
// Port-level checker for the three-group quota assignment block.
// Watches the top level's channels only; bound to the top level below. Uses tgq_pkg.
module tgq_checker
    import tgq_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Result dropped while stalled.");

    a_infeasible_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.feasible |-> o_out_data.min_cost == '0)
        else $error("Infeasible result carries a nonzero cost.");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("Reset did not clear the output and start the table sweep.");

    a_no_result_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_in_data.last_item |=> !$rose(o_out_valid))
        else $error("A result appeared after an item that is not last.");

endmodule

bind three_group_quota_assignment_dp_top tgq_checker u_tgq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[sim/tb.sv]
// Testbench for the three-group quota assignment block.
// Drives directed and random cost sequences and checks every result against its own
// dynamic-programming predictor; needs tgq_pkg and three_group_quota_assignment_dp_top.
`timescale 1ns / 1ps

module tb;
    import tgq_pkg::*;

    localparam int Dim = 256;
    localparam longint CycleLimit = 4000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_item           i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_item          o_out_data;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [CapW-1:0]    i_cfg_data;

    three_group_quota_assignment_dp_top uut (.*);

    logic [SumW-1:0] best_cost [0:Dim*Dim-1];
    logic [CntW-1:0] cell_step [0:Dim*Dim-1];
    int unsigned     seq_pos;
    int unsigned     quota_x, quota_y, quota_z;
    t_out_item       pending_results[$];
    int              errors;
    int              send_idle_pct, recv_idle_pct;
    longint          cycles;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result min_cost=%0d feasible=%0b", $time,
                         o_out_data.min_cost, o_out_data.feasible);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (want.min_cost !== o_out_data.min_cost) begin
                    $display("%0t: min_cost expected %0d actual %0d", $time,
                             want.min_cost, o_out_data.min_cost);
                    errors++;
                end
                if (want.feasible !== o_out_data.feasible) begin
                    $display("%0t: feasible expected %0b actual %0b", $time,
                             want.feasible, o_out_data.feasible);
                    errors++;
                end
            end
        end
    end

    function automatic logic [SumW-1:0] add_sat(input logic [SumW-1:0] a,
                                                input logic [CostW-1:0] b);
        logic [SumW:0] s;
        s = {1'b0, a} + {17'd0, b};
        return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
    endfunction

    function automatic void lower_cell(input int idx, input logic [CntW-1:0] stp,
                                       input logic [SumW-1:0] val);
        if (cell_step[idx] != stp || best_cost[idx] > val) begin
            cell_step[idx] = stp;
            best_cost[idx] = val;
        end
    endfunction

    // Advances the assignment table by one item; returns 1 with the result on a last item.
    function automatic bit assign_item(input t_in_item it, output t_out_item res);
        int ax, ay, az, uz, idx;
        int unsigned n;
        logic [SumW-1:0] base;
        bit ok;
        ax = (quota_x > 255) ? 255 : quota_x;
        ay = (quota_y > 255) ? 255 : quota_y;
        az = quota_z;
        n = seq_pos;
        res = '0;
        if (n == 0) begin
            for (int k = 0; k < Dim*Dim; k++) cell_step[k] = '0;
            best_cost[0] = '0;
            cell_step[0] = 10'd1;
        end
        if (n <= 1021) begin
            for (int ux = ax; ux >= 0; ux--) begin
                for (int uy = ay; uy >= 0; uy--) begin
                    uz = int'(n) - ux - uy;
                    idx = ux * Dim + uy;
                    if (uz < 0 || uz > az) continue;
                    if (cell_step[idx] != CntW'(n + 1)) continue;
                    base = best_cost[idx];
                    if (ux != ax) lower_cell(idx + Dim, CntW'(n + 2), add_sat(base, it.cost_x));
                    if (uy != ay) lower_cell(idx + 1, CntW'(n + 2), add_sat(base, it.cost_y));
                    if (uz != az) lower_cell(idx, CntW'(n + 2), add_sat(base, it.cost_z));
                end
            end
        end
        seq_pos = (n < 1023) ? n + 1 : 1023;
        if (!it.last_item) return 0;
        idx = ax * Dim + ay;
        ok = (n <= 1021) && (cell_step[idx] == CntW'(n + 2));
        res.min_cost = ok ? best_cost[idx] : '0;
        res.feasible = ok;
        seq_pos = 0;
        return 1;
    endfunction

    task automatic send_item(input t_in_item it);
        t_out_item res;
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (assign_item(it, res)) pending_results.push_back(res);
    endtask

    task automatic send_costs(input int cx, input int cy, input int cz, input bit last);
        t_in_item it;
        it.cost_x = CostW'(cx);
        it.cost_y = CostW'(cy);
        it.cost_z = CostW'(cz);
        it.last_item = last;
        send_item(it);
    endtask

    task automatic send_random_sequence(input int len);
        for (int k = 0; k < len; k++)
            send_costs($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                       k == len - 1);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (3 * (quota_x + 1) * (quota_y + 1) + 20) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CapW'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CfgCapX: quota_x = val & 8'hFF;
            CfgCapY: quota_y = val & 8'hFF;
            default: quota_z = val & 8'hFF;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_quotas(input int x, input int y, input int z);
        drain();
        write_reg(CfgCapX, x);
        write_reg(CfgCapY, y);
        write_reg(CfgCapZ, z);
    endtask

    task automatic test_small_feasible();
        set_quotas(1, 1, 1);
        send_costs(0, 16'hFFFF, 16'h8000, 0);
        send_costs(16'hFFFF, 0, 1, 0);
        send_costs(16'h5555, 16'hAAAA, 0, 1);
        send_costs(7, 9, 3, 0);
        send_costs(2, 1, 16'hFFFF, 1);
    endtask

    task automatic test_no_assignment();
        set_quotas(2, 0, 0);
        send_costs(10, 20, 30, 1);
        set_quotas(0, 0, 0);
        send_costs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        set_quotas(0, 0, 1);
        send_costs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
    endtask

    task automatic test_quota_change_mid_sequence();
        set_quotas(2, 2, 2);
        send_costs(5, 6, 7, 0);
        send_costs(8, 3, 1, 0);
        set_quotas(1, 1, 0);
        send_costs(4, 4, 4, 1);
    endtask

    task automatic test_extreme_quotas();
        set_quotas(255, 0, 255);
        send_costs(1, 2, 3, 0);
        send_costs(16'hFFFF, 0, 16'hFFFF, 1);
        set_quotas(0, 255, 0);
        send_costs(3, 2, 1, 1);
        set_quotas(255, 255, 255);
        send_costs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
    endtask

    task automatic test_random(input int snd, input int rcv, input int items);
        int sent, cx, cy, cz, len;
        send_idle_pct = snd;
        recv_idle_pct = rcv;
        sent = 0;
        while (sent < items) begin
            cx = $urandom_range(3);
            cy = $urandom_range(3);
            cz = $urandom_range(3);
            set_quotas(cx, cy, cz);
            for (int s = 0; s < 3; s++) begin
                if ($urandom_range(3) == 0) len = $urandom_range(1, 10);
                else len = cx + cy + $urandom_range(cz) + 1;
                send_random_sequence(len);
                sent += len;
            end
        end
    endtask

    initial begin
        seq_pos = 0;
        quota_x = 0;
        quota_y = 0;
        quota_z = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CfgCapX;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_small_feasible();
        test_no_assignment();
        test_quota_change_mid_sequence();
        test_extreme_quotas();
        test_random(29, 45, 28);
        test_random(45, 29, 28);
        test_random(0, 0, 28);

        drain();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
